FILE: rtl/skp_pkg.sv
package skp_pkg;

  // field widths fixed by the interface
  localparam int unsigned DimW   = 4;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned PosW   = 6;
  localparam int unsigned DataW  = 16;
  localparam int unsigned CfgIdxW = 2;
  // alpha*a is exact in 33 bits
  localparam int unsigned PreW   = 2 * DataW + 1;
  localparam int unsigned QDepth = 2;

  localparam int unsigned MaxOuterDef = 8;
  localparam int unsigned MaxInnerDef = 8;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgSubDim  = 2'd0,
    CfgScaleRe = 2'd1,
    CfgScaleIm = 2'd2
  } cfg_idx_e;

  localparam logic [DimW-1:0]  SubDimRst  = 4'd2;
  localparam logic [DataW-1:0] ScaleReRst = 16'd2048;
  localparam logic [DataW-1:0] ScaleImRst = 16'd0;

  // command between front and back; a load uses row, col and the low
  // bits of x_re/x_im, a run uses the bases and the full prefactor
  typedef struct packed {
    logic                   is_load;
    logic [IdxW-1:0]        row;
    logic [IdxW-1:0]        col;
    logic [PosW-1:0]        base_row;
    logic [PosW-1:0]        base_col;
    logic signed [PreW-1:0] x_re;
    logic signed [PreW-1:0] x_im;
  } skp_cmd_t;

  // side length clamped into one to max_inner
  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] d,
                                              input int unsigned max_inner);
    logic [DimW-1:0] r;
    if (d == '0) begin
      r = DimW'(1);
    end else if (32'(d) > max_inner) begin
      r = DimW'(max_inner);
    end else begin
      r = d;
    end
    return r;
  endfunction

endpackage

FILE: rtl/skp_front.sv
module skp_front #(
  parameter int unsigned MAX_OUTER = skp_pkg::MaxOuterDef,
  parameter int unsigned MAX_INNER = skp_pkg::MaxInnerDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        req_type_i,
  input  logic [skp_pkg::IdxW-1:0]    elem_row_i,
  input  logic [skp_pkg::IdxW-1:0]    elem_col_i,
  input  logic signed [skp_pkg::DataW-1:0] value_re_i,
  input  logic signed [skp_pkg::DataW-1:0] value_im_i,
  input  logic [skp_pkg::DimW-1:0]    dim_i,
  input  logic signed [skp_pkg::DataW-1:0] scale_re_i,
  input  logic signed [skp_pkg::DataW-1:0] scale_im_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output skp_pkg::skp_cmd_t           q_data_o
);
  import skp_pkg::*;

  logic                     st_v_q, st_v_d;
  logic                     st_load_q;
  logic [IdxW-1:0]          st_row_q, st_col_q;
  logic [PosW-1:0]          st_brow_q, st_bcol_q;
  logic signed [DataW-1:0]  st_vre_q, st_vim_q;
  logic signed [2*DataW-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q;

  logic accept, keep, push;
  logic [2*IdxW:0] brow_full, bcol_full;

  // classify: loads outside the table and A elements outside the
  // outer range are dropped here
  always_comb begin
    if (req_type_i == 1'b0) begin
      keep = (32'(elem_row_i) < MAX_INNER) && (32'(elem_col_i) < MAX_INNER);
    end else begin
      keep = (32'(elem_row_i) < MAX_OUTER) && (32'(elem_col_i) < MAX_OUTER);
    end
  end

  assign push       = st_v_q && !q_full_i;
  assign in_ready_o = !st_v_q || !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign brow_full = (2*IdxW+1)'(elem_row_i) * (2*IdxW+1)'(dim_i);
  assign bcol_full = (2*IdxW+1)'(elem_col_i) * (2*IdxW+1)'(dim_i);

  always_comb begin
    st_v_d = st_v_q;
    if (accept) begin
      st_v_d = keep;
    end else if (push) begin
      st_v_d = 1'b0;
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q <= 1'b0;
    end else begin
      st_v_q <= st_v_d;
    end
  end

  // stage payload with the four partial products of alpha*a
  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_load_q <= !req_type_i;
      st_row_q  <= elem_row_i;
      st_col_q  <= elem_col_i;
      st_brow_q <= brow_full[PosW-1:0];
      st_bcol_q <= bcol_full[PosW-1:0];
      st_vre_q  <= value_re_i;
      st_vim_q  <= value_im_i;
      p_rr_q    <= scale_re_i * value_re_i;
      p_ii_q    <= scale_im_i * value_im_i;
      p_ri_q    <= scale_re_i * value_im_i;
      p_ir_q    <= scale_im_i * value_re_i;
    end
  end

  // command towards the queue
  always_comb begin
    q_data_o.is_load  = st_load_q;
    q_data_o.row      = st_row_q;
    q_data_o.col      = st_col_q;
    q_data_o.base_row = st_brow_q;
    q_data_o.base_col = st_bcol_q;
    if (st_load_q) begin
      q_data_o.x_re = PreW'(st_vre_q);
      q_data_o.x_im = PreW'(st_vim_q);
    end else begin
      q_data_o.x_re = PreW'(p_rr_q) - PreW'(p_ii_q);
      q_data_o.x_im = PreW'(p_ri_q) + PreW'(p_ir_q);
    end
  end

  assign q_push_o = push;

endmodule

FILE: rtl/skp_queue.sv
module skp_queue #(
  parameter int unsigned Depth = skp_pkg::QDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  skp_pkg::skp_cmd_t data_i,
  output logic              full_o,
  output logic              head_valid_o,
  output skp_pkg::skp_cmd_t head_o,
  input  logic              pop_i
);
  import skp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  skp_cmd_t          slot_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o       = (32'(cnt_q) == Depth);
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = slot_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == Depth - 1) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == Depth - 1) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: rtl/skp_back.sv
module skp_back #(
  parameter int unsigned MAX_INNER = skp_pkg::MaxInnerDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [skp_pkg::DimW-1:0]         dim_i,
  input  logic                             head_valid_i,
  input  skp_pkg::skp_cmd_t                head_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [skp_pkg::PosW-1:0]         out_row_o,
  output logic [skp_pkg::PosW-1:0]         out_col_o,
  output logic signed [skp_pkg::DataW-1:0] prod_re_o,
  output logic signed [skp_pkg::DataW-1:0] prod_im_o,
  output logic                             run_last_o,
  output logic                             clipped_o
);
  import skp_pkg::*;

  localparam int unsigned BDepth = MAX_INNER * MAX_INNER;
  localparam int unsigned AddrW  = (BDepth > 1) ? $clog2(BDepth) : 1;
  localparam int unsigned MulW   = PreW + DataW;
  localparam int unsigned SumW   = MulW + 1;
  localparam int unsigned Frac   = 22;
  localparam int unsigned QW     = SumW - Frac;

  typedef struct packed {
    logic                  clip;
    logic signed [DataW-1:0] val;
  } rnd_t;

  // round to nearest with ties up, then saturate to Q4.11
  function automatic rnd_t round_sat(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] r;
    logic signed [QW-1:0]   q;
    rnd_t                   o;
    r = v + (SumW'(1) <<< (Frac - 1));
    q = r[SumW-1:Frac];
    if (q > QW'(32767)) begin
      o.clip = 1'b1;
      o.val  = 16'sh7FFF;
    end else if (q < -QW'(32768)) begin
      o.clip = 1'b1;
      o.val  = -16'sh8000;
    end else begin
      o.clip = 1'b0;
      o.val  = q[DataW-1:0];
    end
    return o;
  endfunction

  // B table
  logic [DataW-1:0] bmat_re [BDepth];
  logic [DataW-1:0] bmat_im [BDepth];

  // current run
  logic                   busy_q;
  logic [IdxW-1:0]        k_q, l_q;
  logic [PosW-1:0]        brow_q, bcol_q;
  logic signed [PreW-1:0] pre_re_q, pre_im_q;

  // read stage
  logic                   s1_v_q;
  logic signed [DataW-1:0] b_re_q, b_im_q;
  logic [PosW-1:0]        s1_row_q, s1_col_q;
  logic                   s1_last_q;

  // product stage
  logic                   s2_v_q;
  logic signed [MulW-1:0] m_rr_q, m_ii_q, m_ri_q, m_ir_q;
  logic [PosW-1:0]        s2_row_q, s2_col_q;
  logic                   s2_last_q;

  // output register
  logic                   out_v_q;

  logic              adv, issue, pop, k_end, l_end;
  logic [AddrW-1:0]  wr_addr, rd_addr;
  logic signed [SumW-1:0] sum_re, sum_im;
  rnd_t              rnd_re, rnd_im;

  assign adv   = !out_v_q || out_ready_i;
  assign pop   = head_valid_i && !busy_q && adv;
  assign issue = busy_q && adv;
  assign pop_o = pop;
  assign l_end = ({1'b0, l_q} == dim_i - DimW'(1));
  assign k_end = ({1'b0, k_q} == dim_i - DimW'(1));

  assign wr_addr = AddrW'(32'(head_i.row) * MAX_INNER + 32'(head_i.col));
  assign rd_addr = AddrW'(32'(k_q) * MAX_INNER + 32'(l_q));

  // sequencer over the m by m elements of B
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      k_q    <= '0;
      l_q    <= '0;
    end else begin
      if (pop && !head_i.is_load) begin
        busy_q <= 1'b1;
        k_q    <= '0;
        l_q    <= '0;
      end else if (issue) begin
        if (l_end) begin
          l_q <= '0;
          k_q <= k_q + IdxW'(1);
          if (k_end) begin
            busy_q <= 1'b0;
          end
        end else begin
          l_q <= l_q + IdxW'(1);
        end
      end
    end
  end

  // run parameters
  always_ff @(posedge clk_i) begin
    if (pop && !head_i.is_load) begin
      brow_q   <= head_i.base_row;
      bcol_q   <= head_i.base_col;
      pre_re_q <= head_i.x_re;
      pre_im_q <= head_i.x_im;
    end
  end

  // table write on load, registered read on issue
  always_ff @(posedge clk_i) begin
    if (pop && head_i.is_load) begin
      bmat_re[wr_addr] <= head_i.x_re[DataW-1:0];
      bmat_im[wr_addr] <= head_i.x_im[DataW-1:0];
    end
    if (issue) begin
      b_re_q <= bmat_re[rd_addr];
      b_im_q <= bmat_im[rd_addr];
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= issue;
      s2_v_q  <= s1_v_q;
      out_v_q <= s2_v_q;
    end
  end

  // read stage position and products
  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_row_q  <= brow_q + PosW'(k_q);
      s1_col_q  <= bcol_q + PosW'(l_q);
      s1_last_q <= k_end && l_end;
    end
    if (adv) begin
      m_rr_q    <= pre_re_q * b_re_q;
      m_ii_q    <= pre_im_q * b_im_q;
      m_ri_q    <= pre_re_q * b_im_q;
      m_ir_q    <= pre_im_q * b_re_q;
      s2_row_q  <= s1_row_q;
      s2_col_q  <= s1_col_q;
      s2_last_q <= s1_last_q;
    end
  end

  assign sum_re = SumW'(m_rr_q) - SumW'(m_ii_q);
  assign sum_im = SumW'(m_ri_q) + SumW'(m_ir_q);
  assign rnd_re = round_sat(sum_re);
  assign rnd_im = round_sat(sum_im);

  // output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_row_o  <= s2_row_q;
      out_col_o  <= s2_col_q;
      prod_re_o  <= rnd_re.val;
      prod_im_o  <= rnd_im.val;
      run_last_o <= s2_last_q;
      clipped_o  <= rnd_re.clip || rnd_im.clip;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

FILE: rtl/scaled_complex_kronecker_product_unit.sv
// path: front stage register, queue, sequencer, read, product and output registers
// throughput: one product per cycle while out_ready_i allows; an A element holds the
// back end, and no further command is popped, until the single B table read port has
// stepped through the m*m used entries; a B load gives no product
// reset: asynchronous, active low; clears control state and sets sub_dim 2, alpha 1.0
// the B table is not cleared and holds unknown data until loaded
module scaled_complex_kronecker_product_unit #(
  parameter int unsigned MAX_OUTER = skp_pkg::MaxOuterDef,
  parameter int unsigned MAX_INNER = skp_pkg::MaxInnerDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic                             req_type_i,
  input  logic [skp_pkg::IdxW-1:0]         elem_row_i,
  input  logic [skp_pkg::IdxW-1:0]         elem_col_i,
  input  logic signed [skp_pkg::DataW-1:0] value_re_i,
  input  logic signed [skp_pkg::DataW-1:0] value_im_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [skp_pkg::PosW-1:0]         out_row_o,
  output logic [skp_pkg::PosW-1:0]         out_col_o,
  output logic signed [skp_pkg::DataW-1:0] prod_re_o,
  output logic signed [skp_pkg::DataW-1:0] prod_im_o,
  output logic                             run_last_o,
  output logic                             clipped_o,
  input  logic                             cfg_we_i,
  input  logic [skp_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [skp_pkg::DataW-1:0]        cfg_data_i
);
  import skp_pkg::*;

  logic [DimW-1:0]         sub_dim_q;
  logic signed [DataW-1:0] scale_re_q, scale_im_q;
  logic [DimW-1:0]         dim;

  logic     q_push, q_full, q_head_v, q_pop;
  skp_cmd_t q_in, q_head;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_dim_q  <= SubDimRst;
      scale_re_q <= ScaleReRst;
      scale_im_q <= ScaleImRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgSubDim:  sub_dim_q  <= cfg_data_i[DimW-1:0];
        CfgScaleRe: scale_re_q <= cfg_data_i;
        CfgScaleIm: scale_im_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign dim = eff_dim(sub_dim_q, MAX_INNER);

  skp_front #(
    .MAX_OUTER(MAX_OUTER),
    .MAX_INNER(MAX_INNER)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .req_type_i,
    .elem_row_i,
    .elem_col_i,
    .value_re_i,
    .value_im_i,
    .dim_i      (dim),
    .scale_re_i (scale_re_q),
    .scale_im_i (scale_im_q),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  skp_queue #(
    .Depth(QDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i       (q_push),
    .data_i       (q_in),
    .full_o       (q_full),
    .head_valid_o (q_head_v),
    .head_o       (q_head),
    .pop_i        (q_pop)
  );

  skp_back #(
    .MAX_INNER(MAX_INNER)
  ) u_back (
    .clk_i,
    .rst_ni,
    .dim_i        (dim),
    .head_valid_i (q_head_v),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .out_valid_o,
    .out_ready_i,
    .out_row_o,
    .out_col_o,
    .prod_re_o,
    .prod_im_o,
    .run_last_o,
    .clipped_o
  );

endmodule

FILE: bench/kron_tb_pkg.sv
package kron_tb_pkg;

  // kind of an input transfer
  typedef enum logic {
    ReqLoadB = 1'b0,
    ReqElemA = 1'b1
  } req_kind_e;

endpackage

FILE: bench/kron_checker.sv
module kron_checker
  import skp_pkg::*;
  import kron_tb_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic                    req_type_i,
  input  logic [IdxW-1:0]         elem_row_i,
  input  logic [IdxW-1:0]         elem_col_i,
  input  logic signed [DataW-1:0] value_re_i,
  input  logic signed [DataW-1:0] value_im_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [PosW-1:0]         out_row_i,
  input  logic [PosW-1:0]         out_col_i,
  input  logic signed [DataW-1:0] prod_re_i,
  input  logic signed [DataW-1:0] prod_im_i,
  input  logic                    run_last_i,
  input  logic                    clipped_i,
  input  logic                    cfg_we_i,
  input  logic [CfgIdxW-1:0]      cfg_idx_i,
  input  logic [DataW-1:0]        cfg_data_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      products_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TableDepth = MaxInnerDef * MaxInnerDef;

  typedef struct packed {
    logic [PosW-1:0]         row;
    logic [PosW-1:0]         col;
    logic signed [DataW-1:0] re;
    logic signed [DataW-1:0] im;
    logic                    last;
    logic                    clip;
  } product_t;

  product_t                expected_q[$];
  logic [DimW-1:0]         side_reg;
  logic signed [DataW-1:0] alpha_re;
  logic signed [DataW-1:0] alpha_im;
  logic signed [DataW-1:0] b_re [TableDepth];
  logic signed [DataW-1:0] b_im [TableDepth];

  // Q16.33 down to Q4.11, nearest with ties upward, saturation flag on top
  function automatic logic [DataW:0] round_q11(input longint v);
    longint q;
    logic   sat;
    q   = (v + (longint'(1) <<< 21)) >>> 22;
    sat = 1'b0;
    if (q > 32767) begin
      q   = 32767;
      sat = 1'b1;
    end else if (q < -32768) begin
      q   = -32768;
      sat = 1'b1;
    end
    return {sat, DataW'(q)};
  endfunction

  task automatic report(input string field, input longint got, input longint want);
    if (fail_count_o < 40) begin
      $display("mismatch on %s of product %0d: got %0d, expected %0d",
               field, products_o, got, want);
    end
    fail_count_o++;
  endtask

  // all products of one A element, k major and l minor
  task automatic predict_products();
    int             m;
    int             addr;
    longint         pr;
    longint         pi;
    longint         br;
    longint         bi;
    logic [DataW:0] rre;
    logic [DataW:0] rim;
    product_t       p;
    if (side_reg == '0) begin
      m = 1;
    end else if (int'(side_reg) > int'(MaxInnerDef)) begin
      m = MaxInnerDef;
    end else begin
      m = int'(side_reg);
    end
    pr = longint'(alpha_re) * longint'(value_re_i) - longint'(alpha_im) * longint'(value_im_i);
    pi = longint'(alpha_re) * longint'(value_im_i) + longint'(alpha_im) * longint'(value_re_i);
    for (int k = 0; k < m; k++) begin
      for (int l = 0; l < m; l++) begin
        addr   = k * MaxInnerDef + l;
        br     = longint'(b_re[addr]);
        bi     = longint'(b_im[addr]);
        rre    = round_q11(pr * br - pi * bi);
        rim    = round_q11(pr * bi + pi * br);
        p.row  = PosW'(int'(elem_row_i) * m + k);
        p.col  = PosW'(int'(elem_col_i) * m + l);
        p.re   = rre[DataW-1:0];
        p.im   = rim[DataW-1:0];
        p.last = (k == m - 1) && (l == m - 1);
        p.clip = rre[DataW] | rim[DataW];
        expected_q.push_back(p);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    product_t want;
    if (!rst_ni) begin
      side_reg     = SubDimRst;
      alpha_re     = ScaleReRst;
      alpha_im     = ScaleImRst;
      fail_count_o = 0;
      products_o   = 0;
      expected_q.delete();
      for (int a = 0; a < TableDepth; a++) begin
        b_re[a] = '0;
        b_im[a] = '0;
      end
    end else begin
      // product transfer against the oldest expectation
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report("presence (none expected)", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_row_i !== want.row) report("out_row", out_row_i, want.row);
          if (out_col_i !== want.col) report("out_col", out_col_i, want.col);
          if (prod_re_i !== want.re) report("prod_re", prod_re_i, want.re);
          if (prod_im_i !== want.im) report("prod_im", prod_im_i, want.im);
          if (run_last_i !== want.last) report("run_last", run_last_i, want.last);
          if (clipped_i !== want.clip) report("clipped", clipped_i, want.clip);
        end
        products_o++;
      end
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSubDim:  side_reg = cfg_data_i[DimW-1:0];
          CfgScaleRe: alpha_re = cfg_data_i;
          CfgScaleIm: alpha_im = cfg_data_i;
          default: ;
        endcase
      end
      // input transfer: update the B table or predict a run of products
      if (in_valid_i && in_ready_i) begin
        if (req_type_i == ReqLoadB) begin
          b_re[int'(elem_row_i) * MaxInnerDef + int'(elem_col_i)] = value_re_i;
          b_im[int'(elem_row_i) * MaxInnerDef + int'(elem_col_i)] = value_im_i;
        end else if (int'(elem_row_i) < int'(MaxOuterDef) &&
                     int'(elem_col_i) < int'(MaxOuterDef)) begin
          predict_products();
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

FILE: bench/testbench.sv
module testbench;
  import skp_pkg::*;
  import kron_tb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit  = 400000;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 16;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic                    req_type_i;
  logic [IdxW-1:0]         elem_row_i;
  logic [IdxW-1:0]         elem_col_i;
  logic signed [DataW-1:0] value_re_i;
  logic signed [DataW-1:0] value_im_i;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [PosW-1:0]         out_row_o;
  logic [PosW-1:0]         out_col_o;
  logic signed [DataW-1:0] prod_re_o;
  logic signed [DataW-1:0] prod_im_o;
  logic                    run_last_o;
  logic                    clipped_o;
  logic                    cfg_we_i;
  logic [CfgIdxW-1:0]      cfg_idx_i;
  logic [DataW-1:0]        cfg_data_i;

  int fail_count;
  int pending;
  int products;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len = 0;
  int cycles = 0;
  int items_sent = 0;
  int loads_sent = 0;
  int settings_done = 0;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  scaled_complex_kronecker_product_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .elem_row_i  (elem_row_i),
    .elem_col_i  (elem_col_i),
    .value_re_i  (value_re_i),
    .value_im_i  (value_im_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .prod_re_o   (prod_re_o),
    .prod_im_o   (prod_im_o),
    .run_last_o  (run_last_o),
    .clipped_o   (clipped_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  kron_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .req_type_i   (req_type_i),
    .elem_row_i   (elem_row_i),
    .elem_col_i   (elem_col_i),
    .value_re_i   (value_re_i),
    .value_im_i   (value_im_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_row_i    (out_row_o),
    .out_col_i    (out_col_o),
    .prod_re_i    (prod_re_o),
    .prod_im_i    (prod_im_o),
    .run_last_i   (run_last_o),
    .clipped_i    (clipped_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .products_o   (products)
  );

  // receiver: random stalls, or a long hold-off counted here
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_len > 0) begin
      out_ready_i <= 1'b0;
      hold_len--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("scaled_complex_kronecker_product_unit test failed");
      $finish;
    end
  end

  // element values biased towards the corners of Q4.11
  function automatic logic [DataW-1:0] rand_val();
    logic [DataW-1:0] v;
    case ($urandom_range(7))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      2: v = '0;
      3: v = $urandom_range(1) ? 16'h0001 : 16'hFFFF;
      4: v = DataW'($urandom_range(4095)) - 16'd2048;
      default: v = DataW'($urandom);
    endcase
    return v;
  endfunction

  // one input transfer, entered and left at a falling edge
  task automatic push_item(input req_kind_e kind, input int row, input int col,
                           input logic [DataW-1:0] re, input logic [DataW-1:0] im);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    elem_row_i <= IdxW'(row);
    elem_col_i <= IdxW'(col);
    value_re_i <= re;
    value_im_i <= im;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
    if (kind == ReqLoadB) loads_sent++;
  endtask

  // nothing outstanding, and loads given time to settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // all three registers, back to back
  task automatic configure(input logic [DataW-1:0] dim_data, input logic [DataW-1:0] sre,
                           input logic [DataW-1:0] sim);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgSubDim;
    cfg_data_i <= dim_data;
    @(negedge clk_i);
    cfg_idx_i  <= CfgScaleRe;
    cfg_data_i <= sre;
    @(negedge clk_i);
    cfg_idx_i  <= CfgScaleIm;
    cfg_data_i <= sim;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    settings_done++;
  endtask

  // new setting, fill the used corner of B, then a random mix of transfers
  task automatic random_phase(input logic [DimW-1:0] dim, input logic [DataW-1:0] sre,
                              input logic [DataW-1:0] sim, input int n, input bit hold);
    int m;
    wait_idle();
    configure({(DataW-DimW)'($urandom), dim}, sre, sim);
    m = (dim == '0) ? 1 : ((int'(dim) > int'(MaxInnerDef)) ? MaxInnerDef : int'(dim));
    for (int r = 0; r < m; r++) begin
      for (int c = 0; c < m; c++) begin
        push_item(ReqLoadB, r, c, rand_val(), rand_val());
      end
    end
    if (hold) hold_len = HoldCycles;
    repeat (n) begin
      if ($urandom_range(9) < 7) begin
        push_item(ReqElemA, $urandom_range(7), $urandom_range(7), rand_val(), rand_val());
      end else begin
        push_item(ReqLoadB, $urandom_range(7), $urandom_range(7), rand_val(), rand_val());
      end
    end
  endtask

  initial begin
    in_valid_i = 1'b0;
    req_type_i = ReqLoadB;
    elem_row_i = '0;
    elem_col_i = '0;
    value_re_i = '0;
    value_im_i = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CfgSubDim;
    cfg_data_i = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset setting, side 2, alpha 1.0: extremes and rounding ties of both signs
    push_item(ReqLoadB, 0, 0, 16'h7FFF, 16'h8000);
    push_item(ReqLoadB, 0, 1, 16'd2048, 16'h0000);
    push_item(ReqLoadB, 1, 0, 16'h8000, 16'h8000);
    push_item(ReqLoadB, 1, 1, 16'd1024, -16'sd1024);
    push_item(ReqElemA, 7, 7, 16'h7FFF, 16'h7FFF);
    push_item(ReqElemA, 0, 0, 16'h8000, 16'h8000);
    push_item(ReqElemA, 3, 5, 16'h0000, 16'h0000);
    push_item(ReqElemA, 1, 2, 16'd2048, 16'h0000);
    push_item(ReqElemA, 0, 7, 16'h0001, 16'h0000);
    push_item(ReqElemA, 6, 1, 16'hFFFF, 16'h0000);
    push_item(ReqElemA, 2, 4, 16'h0000, 16'h0001);

    // side 0 acts as 1, most negative alpha: saturation
    wait_idle();
    configure({(DataW-DimW)'($urandom), 4'd0}, 16'h8000, 16'h8000);
    push_item(ReqElemA, 4, 4, 16'h8000, 16'h8000);
    push_item(ReqElemA, 5, 3, 16'h7FFF, 16'h8000);
    push_item(ReqElemA, 7, 0, 16'h0001, 16'hFFFF);

    // sender idles lightly, receiver heavily, with one long hold-off
    send_idle_pct = 30;
    recv_idle_pct = 69;
    random_phase(4'd3, rand_val(), rand_val(), 30, 1'b1);
    random_phase(4'd8, 16'h7FFF, 16'h0000, 15, 1'b0);

    // the other way round
    send_idle_pct = 69;
    recv_idle_pct = 30;
    random_phase(4'd15, 16'h8000, 16'h7FFF, 15, 1'b0);
    random_phase(4'd1, rand_val(), rand_val(), 35, 1'b0);

    // no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(4'd5, rand_val(), rand_val(), 40, 1'b0);
    random_phase(4'd4, 16'h0000, 16'h7FFF, 20, 1'b0);
    random_phase(4'd2, DataW'($urandom_range(4095)) - 16'd2048, rand_val(), 45, 1'b0);

    wait_idle();
    $display("covered %0d input transfers (%0d loads of B) giving %0d products",
             items_sent, loads_sent, products);
    $display("over %0d register settings, side lengths 0 to 15, and a %0d-cycle output hold-off",
             settings_done, HoldCycles);
    if (fail_count == 0 && pending == 0) begin
      $display("scaled_complex_kronecker_product_unit test passed");
    end else begin
      $display("scaled_complex_kronecker_product_unit test failed");
    end
    $finish;
  end

endmodule
